FILE: hdl/dfcd_pkg.sv
// Shared types and constants for the delta frame command decoder.
// Used by the front parser, the command queue, the back end and the top level.
package dfcd_pkg;

   localparam int ADDR_BITS_DEFAULT   = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Command kinds as they appear on the result channel.
   localparam logic [1:0] KIND_LITERAL = 2'd0;
   localparam logic [1:0] KIND_FILL    = 2'd1;
   localparam logic [1:0] KIND_COPY    = 2'd2;
   localparam logic [1:0] KIND_END     = 2'd3;

   localparam logic [7:0] COPY_ESCAPE_HI = 8'hff;

   // One classified command. A command with emit low only moves the pointer.
   typedef struct packed {
      logic       emit;
      logic [1:0] kind;
      logic [7:0] count;
      logic [7:0] value;
      logic [15:0] src;
   } cmd_entry_type;

endpackage

FILE: hdl/dfcd_front.sv
// Front end of the delta frame command decoder: parses the byte stream and
// classifies it into commands. Depends on dfcd_pkg.
module dfcd_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             stream_byte,
   output logic                   enq_valid,
   output dfcd_pkg::cmd_entry_type enq_entry
);
   import dfcd_pkg::*;

   localparam logic [3:0] PH_HDR0       = 4'd0;
   localparam logic [3:0] PH_HDR1       = 4'd1;
   localparam logic [3:0] PH_HDR2       = 4'd2;
   localparam logic [3:0] PH_CMD        = 4'd3;
   localparam logic [3:0] PH_FILL_COUNT = 4'd4;
   localparam logic [3:0] PH_FILL_VALUE = 4'd5;
   localparam logic [3:0] PH_SKIP_COUNT = 4'd6;
   localparam logic [3:0] PH_COPY_HI    = 4'd7;
   localparam logic [3:0] PH_COPY_LO    = 4'd8;
   localparam logic [3:0] PH_COPY_COUNT = 4'd9;

   logic [3:0]  phase_ff, phase_in;
   logic [7:0]  fill_marker_ff, fill_marker_in;
   logic [7:0]  skip_marker_ff, skip_marker_in;
   logic [7:0]  copy_marker_ff, copy_marker_in;
   logic [7:0]  held_count_ff, held_count_in;
   logic [15:0] held_source_ff, held_source_in;
   logic        found;
   cmd_entry_type entry;

   always_comb begin
      phase_in       = phase_ff;
      fill_marker_in = fill_marker_ff;
      skip_marker_in = skip_marker_ff;
      copy_marker_in = copy_marker_ff;
      held_count_in  = held_count_ff;
      held_source_in = held_source_ff;
      found          = 1'b0;
      entry          = '0;
      case (phase_ff)
         PH_HDR1: begin
            skip_marker_in = stream_byte;
            phase_in       = PH_HDR2;
         end
         PH_HDR2: begin
            copy_marker_in = stream_byte;
            phase_in       = PH_CMD;
         end
         PH_CMD: begin
            // Marker checks run in priority order: fill, skip, copy.
            if (stream_byte == fill_marker_ff) begin
               phase_in = PH_FILL_COUNT;
            end else if (stream_byte == skip_marker_ff) begin
               phase_in = PH_SKIP_COUNT;
            end else if (stream_byte == copy_marker_ff) begin
               phase_in = PH_COPY_HI;
            end else begin
               found       = 1'b1;
               entry.emit  = 1'b1;
               entry.kind  = KIND_LITERAL;
               entry.count = 8'd1;
               entry.value = stream_byte;
            end
         end
         PH_FILL_COUNT: begin
            if (stream_byte == 8'd0) begin
               found      = 1'b1;
               entry.emit = 1'b1;
               entry.kind = KIND_END;
               phase_in   = PH_HDR0;
            end else begin
               held_count_in = stream_byte;
               phase_in      = PH_FILL_VALUE;
            end
         end
         PH_FILL_VALUE: begin
            found       = 1'b1;
            entry.emit  = 1'b1;
            entry.kind  = KIND_FILL;
            entry.count = held_count_ff;
            entry.value = stream_byte;
            phase_in    = PH_CMD;
         end
         PH_SKIP_COUNT: begin
            found    = 1'b1;
            phase_in = PH_CMD;
            if (stream_byte == 8'd0) begin
               // A zero skip writes the skip marker itself.
               entry.emit  = 1'b1;
               entry.kind  = KIND_LITERAL;
               entry.count = 8'd1;
               entry.value = skip_marker_ff;
            end else begin
               entry.emit  = 1'b0;
               entry.count = stream_byte;
            end
         end
         PH_COPY_HI: begin
            if (stream_byte == COPY_ESCAPE_HI) begin
               found       = 1'b1;
               entry.emit  = 1'b1;
               entry.kind  = KIND_LITERAL;
               entry.count = 8'd1;
               entry.value = copy_marker_ff;
               phase_in    = PH_CMD;
            end else begin
               held_source_in = {stream_byte, 8'd0};
               phase_in       = PH_COPY_LO;
            end
         end
         PH_COPY_LO: begin
            held_source_in = {held_source_ff[15:8], stream_byte};
            phase_in       = PH_COPY_COUNT;
         end
         PH_COPY_COUNT: begin
            phase_in = PH_CMD;
            if (stream_byte != 8'd0) begin
               found       = 1'b1;
               entry.emit  = 1'b1;
               entry.kind  = KIND_COPY;
               entry.count = stream_byte;
               entry.src   = held_source_ff;
            end
         end
         default: begin
            fill_marker_in = stream_byte;
            phase_in       = PH_HDR1;
         end
      endcase
   end

   assign enq_valid = accept & found;
   assign enq_entry = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HDR0;
         fill_marker_ff <= 8'd0;
         skip_marker_ff <= 8'd0;
         copy_marker_ff <= 8'd0;
         held_count_ff  <= 8'd0;
         held_source_ff <= 16'd0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         fill_marker_ff <= fill_marker_in;
         skip_marker_ff <= skip_marker_in;
         copy_marker_ff <= copy_marker_in;
         held_count_ff  <= held_count_in;
         held_source_ff <= held_source_in;
      end
   end

   a_header_done: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PH_HDR2 |=> phase_ff == PH_CMD)
      else $error("parser did not enter command phase after the header");

   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      enq_valid && enq_entry.kind == KIND_END && enq_entry.emit |=> phase_ff == PH_HDR0)
      else $error("end of frame did not return the parser to the header");

endmodule

FILE: hdl/dfcd_queue.sv
// Short command queue between the parser and the back end.
// Depends on dfcd_pkg for the command type.
module dfcd_queue #(
   parameter int DEPTH = dfcd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  dfcd_pkg::cmd_entry_type push_entry,
   output logic                   full,
   output logic                   head_valid,
   output dfcd_pkg::cmd_entry_type head_entry,
   input  logic                   pop_en
);
   import dfcd_pkg::*;

   localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   cmd_entry_type entries_ff [DEPTH];
   logic [IdxW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IdxW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full       = (count_ff == CntW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid & ~full;
   assign do_pop     = pop_en & head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IdxW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IdxW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(DEPTH))
      else $error("queue fill count exceeds its depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push_valid && full))
      else $error("command offered to a full queue");

endmodule

FILE: hdl/dfcd_back.sv
// Back end of the delta frame command decoder: owns the frame write pointer,
// turns queued commands into results and holds them in the output register.
// Depends on dfcd_pkg.
module dfcd_back #(
   parameter int ADDR_BITS = dfcd_pkg::ADDR_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  dfcd_pkg::cmd_entry_type head_entry,
   output logic                   pop_en,
   output logic                   out_valid,
   input  logic                   out_taken,
   output logic [1:0]             out_kind,
   output logic [15:0]            out_dest,
   output logic [7:0]             out_len,
   output logic [7:0]             out_value,
   output logic [15:0]            out_src
);
   import dfcd_pkg::*;

   localparam logic [15:0] SRC_MASK = 16'((32'd1 << ADDR_BITS) - 32'd1);

   logic [ADDR_BITS-1:0] pointer_ff, pointer_in;
   logic                 valid_ff, valid_in;
   logic [1:0]           kind_ff;
   logic [15:0]          dest_ff;
   logic [7:0]           len_ff;
   logic [7:0]           value_ff;
   logic [15:0]          src_ff;
   logic                 slot_free;
   logic                 load;

   // A pointer-only command needs no room in the output register.
   assign slot_free = ~valid_ff | out_taken;
   assign pop_en    = head_valid & (~head_entry.emit | slot_free);
   assign load      = pop_en & head_entry.emit;

   always_comb begin
      pointer_in = pointer_ff;
      valid_in   = valid_ff & ~out_taken;
      if (pop_en) begin
         if (head_entry.emit && head_entry.kind == KIND_END) begin
            pointer_in = '0;
         end else begin
            pointer_in = pointer_ff + ADDR_BITS'(head_entry.count);
         end
      end
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pointer_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         pointer_ff <= pointer_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= head_entry.kind;
         dest_ff  <= 16'(pointer_ff);
         len_ff   <= head_entry.count;
         value_ff <= head_entry.value;
         src_ff   <= head_entry.src & SRC_MASK;
      end
   end

   assign out_valid = valid_ff;
   assign out_kind  = kind_ff;
   assign out_dest  = dest_ff;
   assign out_len   = len_ff;
   assign out_value = value_ff;
   assign out_src   = src_ff;

   a_end_clears_pointer: assert property (@(posedge clock) disable iff (reset)
      load && head_entry.kind == KIND_END |=> pointer_ff == '0)
      else $error("write pointer not cleared after end of frame");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> !valid_ff || out_taken)
      else $error("result register loaded while still holding a result");

endmodule

FILE: hdl/delta_frame_command_decoder_core.sv
// The decoder takes one compressed byte per cycle while the queue is not full
// and gives at most one frame-buffer command per byte. A request is taken
// whenever the command queue has room, so with the result side popping freely
// it runs at one byte per clock. A command enters the queue when its last byte
// is taken and is then loaded from the queue head into the output register,
// which drives the result ports, once that register is free. Every queued
// command, including a skip that only moves the pointer and gives no result,
// passes through the back end for its pointer update. The queue depth
// (QUEUE_DEPTH) sets how many commands can build up behind a held result while
// pop is low; full then rises and holds off every request, even one that would
// give no command, until a pop makes room. Depends on dfcd_pkg and the front,
// queue and back modules.
module delta_frame_command_decoder_core #(
   parameter int ADDR_BITS   = dfcd_pkg::ADDR_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = dfcd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_stream_byte,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_cmd_kind,
   output logic [15:0] rsp_dest_addr,
   output logic [7:0]  rsp_run_length,
   output logic [7:0]  rsp_fill_value,
   output logic [15:0] rsp_src_addr
);
   import dfcd_pkg::*;

   logic          accept;
   logic          enq_valid;
   cmd_entry_type enq_entry;
   logic          head_valid;
   cmd_entry_type head_entry;
   logic          pop_en;
   logic          out_valid;

   assign accept = push & ~full;
   assign empty  = ~out_valid;

   dfcd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .stream_byte (req_stream_byte),
      .enq_valid   (enq_valid),
      .enq_entry   (enq_entry)
   );

   dfcd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (enq_valid),
      .push_entry (enq_entry),
      .full       (full),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop_en     (pop_en)
   );

   dfcd_back #(
      .ADDR_BITS (ADDR_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop_en     (pop_en),
      .out_valid  (out_valid),
      .out_taken  (pop),
      .out_kind   (rsp_cmd_kind),
      .out_dest   (rsp_dest_addr),
      .out_len    (rsp_run_length),
      .out_value  (rsp_fill_value),
      .out_src    (rsp_src_addr)
   );

endmodule

FILE: dv/delta_frame_command_decoder_core_tb.sv
// Self-checking testbench for delta_frame_command_decoder_core.
// It needs dfcd_pkg and the decoder RTL. A scoreboard class predicts the frame
// commands from the accepted stream bytes and checks each popped command.
`timescale 1ns / 1ps

module delta_frame_command_decoder_core_tb;
   import dfcd_pkg::*;

   localparam int ADDR_BITS = ADDR_BITS_DEFAULT;
   localparam int IDLE_PCT  = 15;
   localparam int MIXED_ITEMS = 460;

   typedef enum logic [3:0] {
      PH_HEADER_FILL,
      PH_HEADER_SKIP,
      PH_HEADER_COPY,
      PH_COMMAND,
      PH_FILL_COUNT,
      PH_FILL_VALUE,
      PH_SKIP_COUNT,
      PH_COPY_HIGH,
      PH_COPY_LOW,
      PH_COPY_COUNT
   } parse_phase_type;

   typedef struct {
      logic [1:0]  kind;
      logic [15:0] dest;
      logic [7:0]  len;
      logic [7:0]  val;
      logic [15:0] src;
   } frame_cmd_type;

   class frame_command_board;
      logic [7:0]           fill_mark;
      logic [7:0]           skip_mark;
      logic [7:0]           copy_mark;
      parse_phase_type      phase;
      logic [ADDR_BITS-1:0] wptr;
      logic [7:0]           held_count;
      logic [15:0]          held_src;
      frame_cmd_type        due_commands[$];
      int                   errors;

      function new();
         fill_mark  = '0;
         skip_mark  = '0;
         copy_mark  = '0;
         phase      = PH_HEADER_FILL;
         wptr       = '0;
         held_count = '0;
         held_src   = '0;
         errors     = 0;
      endfunction

      function void queue_command(logic [1:0] kind, logic [7:0] len, logic [7:0] val,
                                  logic [15:0] src);
         frame_cmd_type c;
         c.kind = kind;
         c.dest = 16'(wptr);
         c.len  = len;
         c.val  = val;
         c.src  = src;
         due_commands = {due_commands, c};
      endfunction

      function void queue_literal(logic [7:0] val);
         queue_command(KIND_LITERAL, 8'd1, val, 16'h0000);
         wptr = wptr + ADDR_BITS'(1);
      endfunction

      // Works out the command, if any, that one accepted stream byte causes.
      function void note_stream_byte(logic [7:0] b);
         logic [15:0] src_mask;
         src_mask = 16'((64'h1 << ADDR_BITS) - 1);
         case (phase)
            PH_HEADER_SKIP: begin
               skip_mark = b;
               phase = PH_HEADER_COPY;
            end
            PH_HEADER_COPY: begin
               copy_mark = b;
               phase = PH_COMMAND;
            end
            PH_COMMAND: begin
               // Markers are matched in a fixed order, so a later duplicate is never seen.
               if (b == fill_mark) phase = PH_FILL_COUNT;
               else if (b == skip_mark) phase = PH_SKIP_COUNT;
               else if (b == copy_mark) phase = PH_COPY_HIGH;
               else queue_literal(b);
            end
            PH_FILL_COUNT: begin
               if (b == 8'd0) begin
                  queue_command(KIND_END, 8'd0, 8'd0, 16'h0000);
                  wptr = '0;
                  phase = PH_HEADER_FILL;
               end else begin
                  held_count = b;
                  phase = PH_FILL_VALUE;
               end
            end
            PH_FILL_VALUE: begin
               phase = PH_COMMAND;
               queue_command(KIND_FILL, held_count, b, 16'h0000);
               wptr = wptr + ADDR_BITS'(held_count);
            end
            PH_SKIP_COUNT: begin
               phase = PH_COMMAND;
               if (b == 8'd0) queue_literal(skip_mark);
               else wptr = wptr + ADDR_BITS'(b);
            end
            PH_COPY_HIGH: begin
               if (b == COPY_ESCAPE_HI) begin
                  phase = PH_COMMAND;
                  queue_literal(copy_mark);
               end else begin
                  held_src = {b, 8'h00};
                  phase = PH_COPY_LOW;
               end
            end
            PH_COPY_LOW: begin
               held_src = {held_src[15:8], b};
               phase = PH_COPY_COUNT;
            end
            PH_COPY_COUNT: begin
               phase = PH_COMMAND;
               if (b != 8'd0) begin
                  queue_command(KIND_COPY, b, 8'd0, held_src & src_mask);
                  wptr = wptr + ADDR_BITS'(b);
               end
            end
            default: begin
               fill_mark = b;
               phase = PH_HEADER_SKIP;
            end
         endcase
      endfunction

      task report_mismatch(string what);
         errors++;
         $display("mismatch at %0t: %s", $realtime, what);
      endtask

      task check_command(logic [1:0] kind, logic [15:0] dest, logic [7:0] len,
                         logic [7:0] val, logic [15:0] src);
         frame_cmd_type want;
         if (due_commands.size() == 0) begin
            report_mismatch($sformatf("unexpected command kind %0d dest %h", kind, dest));
            return;
         end
         want = due_commands.pop_front();
         if (kind !== want.kind)
            report_mismatch($sformatf("cmd_kind %0d, predicted %0d", kind, want.kind));
         if (dest !== want.dest)
            report_mismatch($sformatf("dest_addr %h, predicted %h", dest, want.dest));
         if (len !== want.len)
            report_mismatch($sformatf("run_length %h, predicted %h", len, want.len));
         if (val !== want.val)
            report_mismatch($sformatf("fill_value %h, predicted %h", val, want.val));
         if (src !== want.src)
            report_mismatch($sformatf("src_addr %h, predicted %h", src, want.src));
      endtask
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [7:0]  req_stream_byte = 8'h00;
   logic        empty;
   logic        pop = 1'b0;
   logic [1:0]  rsp_cmd_kind;
   logic [15:0] rsp_dest_addr;
   logic [7:0]  rsp_run_length;
   logic [7:0]  rsp_fill_value;
   logic [15:0] rsp_src_addr;

   frame_command_board sb = new();
   bit calm = 1'b0;
   int bytes_sent = 0;

   // Header with fill 00, skip ff, copy 80, then one of each command and its escapes.
   logic [7:0] directed_bytes [23] = '{
      8'h00, 8'hff, 8'h80,
      8'h7f,
      8'h00, 8'hff, 8'hff,
      8'hff, 8'h00,
      8'hff, 8'h10,
      8'h80, 8'hff,
      8'h80, 8'h12, 8'h34, 8'h05,
      8'h80, 8'hfe, 8'hff, 8'h00,
      8'h00, 8'h00
   };

   delta_frame_command_decoder_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_stream_byte (req_stream_byte),
      .empty           (empty),
      .pop             (pop),
      .rsp_cmd_kind    (rsp_cmd_kind),
      .rsp_dest_addr   (rsp_dest_addr),
      .rsp_run_length  (rsp_run_length),
      .rsp_fill_value  (rsp_fill_value),
      .rsp_src_addr    (rsp_src_addr)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(negedge clock) begin
      pop <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty)
         sb.check_command(rsp_cmd_kind, rsp_dest_addr, rsp_run_length,
                          rsp_fill_value, rsp_src_addr);
   end

   // Called at a falling edge; returns at the falling edge after the request is taken.
   task automatic send_byte(input logic [7:0] value);
      if (!calm) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            push <= 1'b0;
            @(negedge clock);
         end
      end
      push <= 1'b1;
      req_stream_byte <= value;
      @(posedge clock);
      while (full) @(posedge clock);
      sb.note_stream_byte(value);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic drain_commands();
      push <= 1'b0;
      do @(negedge clock); while (sb.due_commands.size() != 0);
   endtask

   // 0: any markers, 1: markers drawn from a tiny pool so that they collide,
   // 2: three distinct markers.
   task automatic send_header(input int style);
      logic [7:0] f, s, c;
      f = 8'($urandom);
      s = 8'($urandom);
      c = 8'($urandom);
      if (style == 1) begin
         f = 8'($urandom_range(2));
         s = 8'($urandom_range(2));
         c = 8'($urandom_range(2));
      end else if (style == 2) begin
         while (s == f) s = 8'($urandom);
         while (c == f || c == s) c = 8'($urandom);
      end
      send_byte(f);
      send_byte(s);
      send_byte(c);
   endtask

   // Sends one well-formed command built from the current markers. With big set,
   // most commands are long skips and fills that move the pointer fast.
   task automatic send_command(input bit big);
      int r;
      logic [7:0] b;
      r = $urandom_range(99);
      if (big && r < 75) begin
         send_byte(sb.skip_mark);
         send_byte(8'($urandom_range(255, 200)));
      end else if (big && r < 90) begin
         send_byte(sb.fill_mark);
         send_byte(8'($urandom_range(255, 200)));
         send_byte(8'($urandom));
      end else begin
         r = $urandom_range(99);
         if (r < 35) begin
            do b = 8'($urandom);
            while (b == sb.fill_mark || b == sb.skip_mark || b == sb.copy_mark);
            send_byte(b);
         end else if (r < 50) begin
            send_byte(sb.fill_mark);
            send_byte(8'($urandom_range(255, 1)));
            send_byte(8'($urandom));
         end else if (r < 65) begin
            send_byte(sb.skip_mark);
            send_byte(($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(255, 1)));
         end else if (r < 72) begin
            send_byte(sb.copy_mark);
            send_byte(COPY_ESCAPE_HI);
         end else begin
            send_byte(sb.copy_mark);
            send_byte(8'($urandom_range(254)));
            send_byte(8'($urandom));
            send_byte(($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(255, 1)));
         end
      end
   endtask

   initial begin
      int n, mixed_start;
      bit paused;

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
      drain_commands();

      // One frame of long fills and skips that moves the write pointer in large steps.
      send_header(2);
      n = 0;
      while (n < 30) begin
         send_command(1'b1);
         n++;
      end
      send_byte(sb.fill_mark);
      send_byte(8'd0);

      mixed_start = bytes_sent;
      paused = 1'b0;
      while (bytes_sent - mixed_start < MIXED_ITEMS) begin
         calm = (bytes_sent - mixed_start >= 150) && (bytes_sent - mixed_start < 300);
         if (!paused && bytes_sent - mixed_start >= 100) begin
            drain_commands();
            paused = 1'b1;
         end
         // Now and then a burst of arbitrary bytes breaks the frame structure.
         if ($urandom_range(99) < 10) begin
            n = $urandom_range(6, 1);
            repeat (n) send_byte(8'($urandom));
         end
         send_header(($urandom_range(3) == 0) ? 1 : 0);
         n = $urandom_range(25, 1);
         repeat (n) send_command(1'b0);
         if ($urandom_range(9) != 0) begin
            send_byte(sb.fill_mark);
            send_byte(8'd0);
         end
      end
      calm = 1'b0;
      push <= 1'b0;

      while (sb.due_commands.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (sb.errors == 0 && sb.due_commands.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
